/* rtl/core/bbuf_pkg.sv */
// Package for the LSB-first bit buffer: sizes, request and status codes,
// sequencer states and shift unit modes. No dependencies.
package bbuf_pkg;

  localparam int CAP_BYTES = 1024;
  localparam int IDX_W     = $clog2(CAP_BYTES);
  localparam int LEN_W     = 14;
  localparam int REQ_W     = 3;
  localparam int VAL_W     = 8;
  localparam int ST_W      = 2;
  localparam int SH_W      = 3;

  localparam logic [LEN_W:0] CAP_BITS = (LEN_W + 1)'(CAP_BYTES * 8);

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  typedef enum logic [REQ_W-1:0] {
    REQ_STORE_BIT  = 3'd0,
    REQ_STORE_BYTE = 3'd1,
    REQ_REMOVE     = 3'd2,
    REQ_TRUNCATE   = 3'd3,
    REQ_READ_BIT   = 3'd4,
    REQ_READ_BYTE  = 3'd5,
    REQ_CLEAR      = 3'd6
  } req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MERGE,
    S_WR_HI,
    S_RD_LO,
    S_RD_HI
  } state_t;

  typedef enum logic {
    SH_INSERT,
    SH_EXTRACT
  } sh_op_t;

endpackage

/* rtl/core/bbuf_ram.sv */
// Generic single write, single read port RAM with registered read data.
// No dependencies.
module bbuf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/bbuf_shift.sv */
// Shared 16-bit rotate unit: aligns a byte into a byte pair for stores and
// pulls a byte out of a byte pair for reads. Depends on bbuf_pkg.
module bbuf_shift (
  input  bbuf_pkg::sh_op_t                op,
  input  logic [bbuf_pkg::SH_W-1:0]       amt,
  input  logic [2*bbuf_pkg::VAL_W-1:0]    din,
  output logic [2*bbuf_pkg::VAL_W-1:0]    dout
);
  import bbuf_pkg::*;

  logic [SH_W:0]        rot;
  logic [4*VAL_W-1:0]   dbl;
  logic [4*VAL_W-1:0]   shifted;

  // insert = rotate left by amt = rotate right by 16 - amt
  assign rot     = (op == SH_EXTRACT) ? {1'b0, amt} : ((SH_W + 1)'(0) - {1'b0, amt});
  assign dbl     = {din, din};
  assign shifted = dbl >> rot;
  assign dout    = shifted[2*VAL_W-1:0];

endmodule

/* rtl/core/lsb_first_bit_buffer.sv */
// Top level of the LSB-first bit buffer: sequencer, length and cursor,
// byte store RAM. Depends on bbuf_pkg, bbuf_ram, bbuf_shift.
//
//  channel | ports                                          | handshake
//  in      | in_req_type, in_write_value, in_new_length     | start & !busy
//  out     | out_read_value, out_bit_length,                | out_valid, 1 cycle
//          | out_read_position, out_status                  |
//
// busy stays high after an input transfer until the last state ends, and the
// result is strobed in the cycle after. EXEC alone serves rejects, remove,
// truncate, clear and aligned stores; bit and aligned byte reads add RD_LO;
// unaligned byte reads add RD_LO, RD_HI; unaligned stores add MERGE (and
// WR_HI for bytes). Reset clears state, length, cursor and out_valid only;
// bytes are merged under a mask. Results are strobed and cannot be stalled.
module lsb_first_bit_buffer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [bbuf_pkg::REQ_W-1:0]  in_req_type,
  input  logic [bbuf_pkg::VAL_W-1:0]  in_write_value,
  input  logic [bbuf_pkg::LEN_W-1:0]  in_new_length,
  output logic                        out_valid,
  output logic [bbuf_pkg::VAL_W-1:0]  out_read_value,
  output logic [bbuf_pkg::LEN_W-1:0]  out_bit_length,
  output logic [bbuf_pkg::LEN_W-1:0]  out_read_position,
  output logic [bbuf_pkg::ST_W-1:0]   out_status
);
  import bbuf_pkg::*;

  state_t              state_r, state_nxt;
  logic [REQ_W-1:0]    req_r;
  logic [VAL_W-1:0]    wv_r;
  logic [LEN_W-1:0]    nl_r;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [LEN_W-1:0]    cur_r, cur_nxt;
  logic [VAL_W-1:0]    lo_r, lo_nxt;

  logic                out_valid_r;
  logic [VAL_W-1:0]    out_rv_r;
  logic [LEN_W-1:0]    out_len_r;
  logic [LEN_W-1:0]    out_cur_r;
  logic [ST_W-1:0]     out_st_r;

  logic [SH_W-1:0]     wsh, rsh;
  logic [IDX_W-1:0]    widx, ridx;
  logic [LEN_W:0]      len_x, cur_x;
  logic [ST_W-1:0]     chk_status;
  logic [VAL_W-1:0]    keep_mask;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr, ram_raddr;
  logic [VAL_W-1:0]    ram_wdata, ram_rdata;

  sh_op_t              sh_op;
  logic [SH_W-1:0]     sh_amt;
  logic [2*VAL_W-1:0]  sh_din, sh_out;

  logic                done;
  logic [VAL_W-1:0]    rv;

  assign wsh       = len_r[SH_W-1:0];
  assign rsh       = cur_r[SH_W-1:0];
  assign widx      = len_r[IDX_W+SH_W-1:SH_W];
  assign ridx      = cur_r[IDX_W+SH_W-1:SH_W];
  assign len_x     = {1'b0, len_r};
  assign cur_x     = {1'b0, cur_r};
  assign keep_mask = ~(8'hFF << wsh);

  bbuf_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAP_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bbuf_shift u_shift (
    .op   (sh_op),
    .amt  (sh_amt),
    .din  (sh_din),
    .dout (sh_out)
  );

  always_comb begin
    case (req_r)
      REQ_STORE_BIT:  chk_status = (len_x >= CAP_BITS) ? ST_FULL : ST_OK;
      REQ_STORE_BYTE: chk_status = (len_x + (LEN_W + 1)'(8) > CAP_BITS) ? ST_FULL : ST_OK;
      REQ_REMOVE:     chk_status = (len_r == '0) ? ST_RANGE : ST_OK;
      REQ_TRUNCATE:   chk_status = (nl_r > len_r) ? ST_RANGE : ST_OK;
      REQ_READ_BIT:   chk_status = (cur_r >= len_r) ? ST_RANGE : ST_OK;
      REQ_READ_BYTE:  chk_status = (cur_x + (LEN_W + 1)'(8) > len_x) ? ST_RANGE : ST_OK;
      REQ_CLEAR:      chk_status = ST_OK;
      default:        chk_status = ST_RANGE;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        if (chk_status == ST_OK) begin
          case (req_r)
            REQ_STORE_BIT, REQ_STORE_BYTE: begin
              if (wsh != '0) state_nxt = S_MERGE;
            end
            REQ_READ_BIT, REQ_READ_BYTE: state_nxt = S_RD_LO;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_MERGE: state_nxt = (req_r == REQ_STORE_BYTE) ? S_WR_HI : S_IDLE;
      S_WR_HI: state_nxt = S_IDLE;
      S_RD_LO: state_nxt = (req_r == REQ_READ_BYTE && rsh != '0) ? S_RD_HI : S_IDLE;
      S_RD_HI: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = widx;
    ram_wdata = '0;
    ram_raddr = ridx;
    sh_op     = SH_INSERT;
    sh_amt    = wsh;
    sh_din    = {{VAL_W{1'b0}}, wv_r};
    done      = 1'b0;
    rv        = '0;
    len_nxt   = len_r;
    cur_nxt   = cur_r;
    lo_nxt    = lo_r;
    case (state_r)
      S_EXEC: begin
        if (chk_status != ST_OK) begin
          done = 1'b1;
        end else begin
          case (req_r)
            REQ_STORE_BIT: begin
              if (wsh == '0) begin
                ram_we    = 1'b1;
                ram_wdata = {{(VAL_W-1){1'b0}}, wv_r[0]};
                done      = 1'b1;
                len_nxt   = len_r + LEN_W'(1);
              end else begin
                ram_raddr = widx;
              end
            end
            REQ_STORE_BYTE: begin
              if (wsh == '0) begin
                ram_we    = 1'b1;
                ram_wdata = wv_r;
                done      = 1'b1;
                len_nxt   = len_r + LEN_W'(8);
              end else begin
                ram_raddr = widx;
              end
            end
            REQ_REMOVE: begin
              done    = 1'b1;
              len_nxt = len_r - LEN_W'(1);
            end
            REQ_TRUNCATE: begin
              done    = 1'b1;
              len_nxt = nl_r;
            end
            REQ_READ_BIT, REQ_READ_BYTE: ram_raddr = ridx;
            REQ_CLEAR: begin
              done    = 1'b1;
              len_nxt = '0;
              cur_nxt = '0;
            end
            default: done = 1'b1;
          endcase
        end
      end
      S_MERGE: begin
        if (req_r == REQ_STORE_BIT) begin
          sh_din = {{(2*VAL_W-1){1'b0}}, wv_r[0]};
        end
        ram_we    = 1'b1;
        ram_wdata = (ram_rdata & keep_mask) | sh_out[VAL_W-1:0];
        if (req_r == REQ_STORE_BIT) begin
          done    = 1'b1;
          len_nxt = len_r + LEN_W'(1);
        end
      end
      S_WR_HI: begin
        ram_we    = 1'b1;
        ram_waddr = widx + IDX_W'(1);
        ram_wdata = sh_out[2*VAL_W-1:VAL_W];
        done      = 1'b1;
        len_nxt   = len_r + LEN_W'(8);
      end
      S_RD_LO: begin
        sh_op  = SH_EXTRACT;
        sh_amt = rsh;
        sh_din = {{VAL_W{1'b0}}, ram_rdata};
        lo_nxt = ram_rdata;
        if (req_r == REQ_READ_BIT) begin
          rv      = {{(VAL_W-1){1'b0}}, sh_out[0]};
          done    = 1'b1;
          cur_nxt = cur_r + LEN_W'(1);
        end else if (rsh == '0) begin
          rv      = sh_out[VAL_W-1:0];
          done    = 1'b1;
          cur_nxt = cur_r + LEN_W'(8);
        end else begin
          ram_raddr = ridx + IDX_W'(1);
        end
      end
      S_RD_HI: begin
        sh_op   = SH_EXTRACT;
        sh_amt  = rsh;
        sh_din  = {ram_rdata, lo_r};
        rv      = sh_out[VAL_W-1:0];
        done    = 1'b1;
        cur_nxt = cur_r + LEN_W'(8);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= done;
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    if (state_r == S_IDLE && start) begin
      req_r <= in_req_type;
      wv_r  <= in_write_value;
      nl_r  <= in_new_length;
    end
    if (done) begin
      out_rv_r  <= rv;
      out_len_r <= len_nxt;
      out_cur_r <= cur_nxt;
      out_st_r  <= chk_status;
    end
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_read_value    = out_rv_r;
  assign out_bit_length    = out_len_r;
  assign out_read_position = out_cur_r;
  assign out_status        = out_st_r;

endmodule
